[rtl/lcm_pkg.sv]
package lcm_pkg;

  localparam int DIV_NW = 40;
  localparam int DIV_DW = 24;
  localparam int SLOTS  = 5;
  localparam int RES_W  = 20;

  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam logic [RES_W-1:0] RES_MAX = '1;

  localparam logic [2:0] REG_LEVEL = 3'd5;
  localparam logic [2:0] REG_LAMP  = 3'd6;

endpackage

[rtl/lcm_div.sv]
module lcm_div import lcm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign trial = {rem_r, num_r[DIV_NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      num_r <= {num_r[DIV_NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

[rtl/led_color_mixer.sv]
// With the lamp off, an accepted item passes S_DONE and then the out_valid register. With
// the lamp on, level scaling runs S_RES, S_RES_W and S_RES_H per channel, then each division
// runs on the shared radix-2 divider; up to 19 divisions per item.
// Throughput: one item at a time; busy falls as out_valid rises and the next item
// may be accepted in that cycle. Result is shown for one cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low): idle, emitters 0, level 255, lamp off.
module led_color_mixer import lcm_pkg::*; #(
  parameter int EMITTERS   = 5,
  parameter int LEVEL_FULL = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_want_red,
  input  logic [7:0]  in_want_green,
  input  logic [7:0]  in_want_blue,
  output logic        out_valid,
  output logic [11:0] out_duty_0,
  output logic [11:0] out_duty_1,
  output logic [11:0] out_duty_2,
  output logic [11:0] out_duty_3,
  output logic [11:0] out_duty_4,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [37:0] cfg_data
);

  // ceil(2^40 / LEVEL_FULL): exact scaling of want*level*4096 by reciprocal multiply
  localparam logic [40:0] RECIP =
    41'(((64'd1 << 40) + 64'(LEVEL_FULL) - 64'd1) / 64'(LEVEL_FULL));
  localparam logic [23:0] RECIP_LO = RECIP[23:0];
  localparam logic [16:0] RECIP_HI = RECIP[40:24];

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_RES     = 20'h00002,
    S_RES_W   = 20'h00004,
    S_CHK     = 20'h00008,
    S_TGT     = 20'h00010,
    S_TGT_W   = 20'h00020,
    S_SEL     = 20'h00040,
    S_SEL_W   = 20'h00080,
    S_PICK    = 20'h00100,
    S_F_W     = 20'h00200,
    S_AP_INIT = 20'h00400,
    S_AP_CH   = 20'h00800,
    S_AP_W    = 20'h01000,
    S_AP_F    = 20'h02000,
    S_AP_DUTY = 20'h04000,
    S_AP_SUB  = 20'h08000,
    S_AP_END  = 20'h10000,
    S_COL     = 20'h20000,
    S_DONE    = 20'h40000,
    S_RES_H   = 20'h80000
  } state_t;

  state_t st_r, st_nxt;

  logic [37:0]       emit_r [SLOTS];
  logic [7:0]        level_r;
  logic              lamp_r;
  logic [7:0]        want_r [3];
  logic [RES_W-1:0]  res_r [3];
  logic [15:0]       p_r, lo_r;
  logic signed [17:0] target_r;
  logic signed [18:0] dpos_r, dneg_r;
  logic              pos_v_r, neg_v_r;
  logic [2:0]        ipos_r, ineg_r, idx_r, cur_r;
  logic [1:0]        ch_r;
  logic [16:0]       f_r, best_r;
  logic [11:0]       duty_r [SLOTS];
  logic              col_r, then_pos_r, out_valid_r;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  logic [16:0] mul_a;
  logic [23:0] mul_b;
  logic [40:0] mul_p;
  logic [33:0] res_sum;

  logic        ap_st;
  logic [2:0]  ea;
  logic [37:0] e;
  logic [7:0]  e_r, e_b, c_w;
  logic        e_pres, e_white, idx_in, sel_ok, any_white, res_nz;
  logic [11:0] e_cal;
  logic [RES_W-1:0] res_sel;
  logic [RES_W:0]   sub_w;
  logic [RES_W-1:0] mag_t;
  logic [7:0]       mag_e;
  logic signed [17:0] bal;
  logic signed [18:0] d;

  lcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign ap_st = (st_r == S_AP_CH) || (st_r == S_AP_W) || (st_r == S_AP_DUTY) ||
                 (st_r == S_AP_SUB);
  assign ea      = ap_st ? cur_r : idx_r;
  assign idx_in  = idx_r < 3'(EMITTERS);
  assign e       = emit_r[ea];
  assign e_r     = e[7:0];
  assign e_b     = e[23:16];
  assign e_cal   = e[35:24];
  assign e_white = e[36];
  assign e_pres  = e[37];
  assign sel_ok  = idx_in && e_pres && e_white && ({1'b0, e_r} + {1'b0, e_b} != 9'd0);

  always_comb begin
    case (ch_r)
      2'd0:    c_w = e[7:0];
      2'd1:    c_w = e[15:8];
      default: c_w = e[23:16];
    endcase
  end

  assign res_sel = res_r[ch_r];
  assign res_nz  = (res_r[0] != '0) && (res_r[1] != '0) && (res_r[2] != '0);

  always_comb begin
    any_white = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i < EMITTERS && emit_r[i][37] && emit_r[i][36]) any_white = 1'b1;
    end
  end

  assign mag_t = (res_r[0] >= res_r[2]) ? res_r[0] - res_r[2] : res_r[2] - res_r[0];
  assign mag_e = (e_r >= e_b) ? e_r - e_b : e_b - e_r;
  assign bal   = (e_r < e_b) ? -$signed({1'b0, div_quo[16:0]})
                             : $signed({1'b0, div_quo[16:0]});
  assign d     = $signed({bal[17], bal}) - $signed({target_r[17], target_r});
  assign sub_w = mul_p[24:4];
  assign res_sum = mul_p[33:0] + {18'b0, lo_r};

  // shared multiplier
  always_comb begin
    mul_a = best_r;
    mul_b = 24'(f_r);
    case (st_r)
      S_RES:     begin mul_a = 17'(want_r[ch_r]); mul_b = 24'(level_r); end
      S_RES_W:   begin mul_a = {1'b0, p_r}; mul_b = RECIP_LO; end
      S_RES_H:   begin mul_a = {1'b0, p_r}; mul_b = 24'(RECIP_HI); end
      S_AP_DUTY: mul_b = 24'(e_cal);
      S_AP_SUB:  mul_b = 24'(c_w);
      default:   ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (st_r)
      S_TGT: begin
        div_start = 1'b1;
        div_num   = DIV_NW'({mag_t, 16'b0});
        div_den   = DIV_DW'({1'b0, res_r[0]} + {1'b0, res_r[2]});
      end
      S_SEL: begin
        div_start = sel_ok;
        div_num   = DIV_NW'({mag_e, 16'b0});
        div_den   = DIV_DW'({1'b0, e_r} + {1'b0, e_b});
      end
      S_PICK: begin
        div_start = pos_v_r && neg_v_r;
        div_num   = DIV_NW'({dpos_r[17:0], 16'b0});
        div_den   = DIV_DW'(dpos_r - dneg_r);
      end
      S_AP_CH: begin
        div_start = (ch_r != 2'd3) && (c_w != 8'd0);
        div_num   = DIV_NW'({res_sel, 4'b0});
        div_den   = DIV_DW'(c_w);
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:    if (start) st_nxt = lamp_r ? S_RES : S_DONE;
      S_RES:     st_nxt = S_RES_W;
      S_RES_W:   st_nxt = S_RES_H;
      S_RES_H:   st_nxt = (ch_r == 2'd2) ? S_CHK : S_RES;
      S_CHK:     st_nxt = (any_white && res_nz) ? S_TGT : S_COL;
      S_TGT:     st_nxt = S_TGT_W;
      S_TGT_W:   if (div_done) st_nxt = S_SEL;
      S_SEL: begin
        if (!idx_in)     st_nxt = S_PICK;
        else if (sel_ok) st_nxt = S_SEL_W;
      end
      S_SEL_W:   if (div_done) st_nxt = S_SEL;
      S_PICK: begin
        if (pos_v_r && neg_v_r)     st_nxt = S_F_W;
        else if (pos_v_r || neg_v_r) st_nxt = S_AP_INIT;
        else                        st_nxt = S_COL;
      end
      S_F_W:     if (div_done) st_nxt = S_AP_INIT;
      S_AP_INIT: st_nxt = S_AP_CH;
      S_AP_CH: begin
        if (ch_r == 2'd3)       st_nxt = S_AP_F;
        else if (c_w != 8'd0)   st_nxt = S_AP_W;
      end
      S_AP_W:    if (div_done) st_nxt = S_AP_CH;
      S_AP_F:    st_nxt = S_AP_DUTY;
      S_AP_DUTY: st_nxt = S_AP_SUB;
      S_AP_SUB:  if (ch_r == 2'd3) st_nxt = S_AP_END;
      S_AP_END:  st_nxt = (!col_r && then_pos_r) ? S_AP_INIT : S_COL;
      S_COL: begin
        if (!idx_in)                 st_nxt = S_DONE;
        else if (e_pres && !e_white) st_nxt = S_AP_INIT;
      end
      S_DONE:    st_nxt = S_IDLE;
      default:   st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      level_r     <= 8'd255;
      lamp_r      <= 1'b0;
      for (int i = 0; i < SLOTS; i++) emit_r[i] <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= (st_r == S_DONE);
      if (cfg_valid) begin
        if (cfg_index < REG_LEVEL)       emit_r[cfg_index] <= cfg_data;
        else if (cfg_index == REG_LEVEL) level_r <= cfg_data[7:0];
        else if (cfg_index == REG_LAMP)  lamp_r  <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (start) begin
        want_r[0] <= in_want_red;
        want_r[1] <= in_want_green;
        want_r[2] <= in_want_blue;
        for (int i = 0; i < SLOTS; i++) duty_r[i] <= '0;
        ch_r <= 2'd0;
      end
      S_RES:   p_r  <= mul_p[15:0];
      S_RES_W: lo_r <= mul_p[39:24];
      S_RES_H: begin
        res_r[ch_r] <= (res_sum[33:24] != '0) ? RES_MAX : res_sum[23:4];
        ch_r        <= ch_r + 2'd1;
        idx_r       <= 3'd0;
      end
      S_CHK: idx_r <= 3'd0;
      S_TGT_W: if (div_done) begin
        target_r <= (res_r[0] < res_r[2]) ? -$signed({1'b0, div_quo[16:0]})
                                          : $signed({1'b0, div_quo[16:0]});
        pos_v_r  <= 1'b0;
        neg_v_r  <= 1'b0;
        dpos_r   <= '0;
        dneg_r   <= '0;
        idx_r    <= 3'd0;
      end
      S_SEL: if (idx_in && !sel_ok) idx_r <= idx_r + 3'd1;
      S_SEL_W: if (div_done) begin
        if (d == '0) begin
          pos_v_r <= 1'b1;
          ipos_r  <= idx_r;
          dpos_r  <= '0;
          neg_v_r <= 1'b0;
          dneg_r  <= '0;
        end else if (d < 0) begin
          if ((!neg_v_r && !(pos_v_r && dpos_r == '0)) || (neg_v_r && d > dneg_r)) begin
            neg_v_r <= 1'b1;
            ineg_r  <= idx_r;
            dneg_r  <= d;
          end
        end else if (!pos_v_r || d < dpos_r) begin
          pos_v_r <= 1'b1;
          ipos_r  <= idx_r;
          dpos_r  <= d;
        end
        idx_r <= idx_r + 3'd1;
      end
      S_PICK: begin
        col_r      <= 1'b0;
        f_r        <= Q16_ONE;
        then_pos_r <= 1'b0;
        cur_r      <= pos_v_r ? ipos_r : ineg_r;
        idx_r      <= 3'd0;
      end
      S_F_W: if (div_done) begin
        f_r        <= div_quo[16:0];
        cur_r      <= ineg_r;
        then_pos_r <= 1'b1;
      end
      S_AP_INIT: begin
        best_r <= Q16_ONE;
        ch_r   <= 2'd0;
      end
      S_AP_CH: if (ch_r != 2'd3 && c_w == 8'd0) ch_r <= ch_r + 2'd1;
      S_AP_W: if (div_done) begin
        if (div_quo < DIV_NW'(best_r)) best_r <= div_quo[16:0];
        ch_r <= ch_r + 2'd1;
      end
      S_AP_F: best_r <= mul_p[32:16];
      S_AP_DUTY: begin
        duty_r[cur_r] <= mul_p[27:16];
        ch_r          <= 2'd0;
      end
      S_AP_SUB: if (ch_r != 2'd3) begin
        res_r[ch_r] <= ({1'b0, res_sel} > sub_w) ? res_sel - sub_w[RES_W-1:0] : '0;
        ch_r        <= ch_r + 2'd1;
      end
      S_AP_END: begin
        if (col_r) begin
          idx_r <= idx_r + 3'd1;
        end else if (then_pos_r) begin
          then_pos_r <= 1'b0;
          cur_r      <= ipos_r;
          f_r        <= Q16_ONE;
        end else begin
          idx_r <= 3'd0;
        end
      end
      S_COL: if (idx_in) begin
        if (e_pres && !e_white) begin
          cur_r <= idx_r;
          f_r   <= Q16_ONE;
          col_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  assign busy       = (st_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_duty_0 = duty_r[0];
  assign out_duty_1 = duty_r[1];
  assign out_duty_2 = duty_r[2];
  assign out_duty_3 = duty_r[3];
  assign out_duty_4 = duty_r[4];

endmodule

[tb/sv/testbench.sv]
module testbench import lcm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_EMIT0 = 3'd0;
  localparam logic [2:0] REG_BAD   = 3'd7;
  localparam int EMITTERS_C   = 5;
  localparam int LEVEL_FULL_C = 255;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_want_red, in_want_green, in_want_blue;
  logic        out_valid;
  logic [11:0] out_duty_0, out_duty_1, out_duty_2, out_duty_3, out_duty_4;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [37:0] cfg_data;

  typedef struct packed {
    logic [11:0] d4, d3, d2, d1, d0;
  } duty_set_t;

  logic [37:0] emit_m [SLOTS];
  logic [7:0]  level_m;
  logic        lamp_m;
  duty_set_t   duty_q [$];
  int          errors;
  int          items_sent;
  int          results_seen;

  led_color_mixer #(.EMITTERS(EMITTERS_C), .LEVEL_FULL(LEVEL_FULL_C)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_want_red(in_want_red), .in_want_green(in_want_green),
    .in_want_blue(in_want_blue), .out_valid(out_valid),
    .out_duty_0(out_duty_0), .out_duty_1(out_duty_1), .out_duty_2(out_duty_2),
    .out_duty_3(out_duty_3), .out_duty_4(out_duty_4),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint signed red_blue_balance(longint unsigned a, longint unsigned b);
    longint unsigned mag;
    longint signed   q;
    mag = (a >= b) ? a - b : b - a;
    q = longint'((mag * 65536) / (a + b));
    return (a >= b) ? q : -q;
  endfunction

  task automatic light_emitter(input int idx, input longint unsigned factor,
                               inout longint unsigned res[3],
                               inout logic [11:0] duty[SLOTS]);
    longint unsigned bright, q, sub, c;
    bright = 65536;
    for (int ch = 0; ch < 3; ch++) begin
      c = emit_m[idx][8*ch +: 8];
      if (c != 0) begin
        q = (res[ch] << 4) / c;
        if (q < bright) bright = q;
      end
    end
    bright = (bright * factor) >> 16;
    duty[idx] = 12'((bright * emit_m[idx][35:24]) >> 16);
    for (int ch = 0; ch < 3; ch++) begin
      sub = (longint'(emit_m[idx][8*ch +: 8]) * bright) >> 4;
      res[ch] = (res[ch] > sub) ? res[ch] - sub : 0;
    end
  endtask

  task automatic mix_color(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           output duty_set_t ds);
    longint unsigned res[3], v, rr, bb, f;
    logic [11:0] duty[SLOTS];
    logic [7:0]  want[3];
    longint signed target, d, dpos, dneg;
    int ipos, ineg;
    bit any_white;
    want[0] = r; want[1] = g; want[2] = b;
    for (int i = 0; i < SLOTS; i++) duty[i] = '0;
    if (lamp_m) begin
      any_white = 0;
      for (int ch = 0; ch < 3; ch++) begin
        v = (longint'(want[ch]) * level_m * 4096) / longint'(LEVEL_FULL_C);
        res[ch] = (v > 1048575) ? 1048575 : v;
      end
      for (int i = 0; i < EMITTERS_C; i++)
        if (emit_m[i][37] && emit_m[i][36]) any_white = 1;
      if (any_white && res[0] != 0 && res[1] != 0 && res[2] != 0) begin
        target = red_blue_balance(res[0], res[2]);
        dpos = 0; dneg = 0; ipos = -1; ineg = -1;
        for (int i = 0; i < EMITTERS_C; i++) begin
          rr = emit_m[i][7:0];
          bb = emit_m[i][23:16];
          if (!emit_m[i][37] || !emit_m[i][36] || rr + bb == 0) continue;
          d = red_blue_balance(rr, bb) - target;
          if (d == 0) begin
            ipos = i; dpos = 0; ineg = -1; dneg = 0;
          end else if (d < 0) begin
            if ((ineg < 0 && !(ipos >= 0 && dpos == 0)) || (ineg >= 0 && d > dneg)) begin
              ineg = i; dneg = d;
            end
          end else begin
            if (ipos < 0 || d < dpos) begin
              ipos = i; dpos = d;
            end
          end
        end
        if (ineg >= 0 && ipos >= 0) begin
          f = (longint'(dpos) * 65536) / longint'(dpos - dneg);
          light_emitter(ineg, f, res, duty);
          light_emitter(ipos, 65536, res, duty);
        end else if (ipos >= 0) begin
          light_emitter(ipos, 65536, res, duty);
        end else if (ineg >= 0) begin
          light_emitter(ineg, 65536, res, duty);
        end
      end
      for (int i = 0; i < EMITTERS_C; i++)
        if (emit_m[i][37] && !emit_m[i][36]) light_emitter(i, 65536, res, duty);
    end
    ds = '{d4: duty[4], d3: duty[3], d2: duty[2], d1: duty[1], d0: duty[0]};
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [37:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < SLOTS) emit_m[idx] = val;
    else if (idx == REG_LEVEL) level_m = val[7:0];
    else if (idx == REG_LAMP) lamp_m = val[0];
  endtask

  // start stays high across back-to-back items; idle_gap and wait_drained lower it
  task automatic send_color(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    duty_set_t ds;
    start <= 1'b1;
    in_want_red <= r;
    in_want_green <= g;
    in_want_blue <= b;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    mix_color(r, g, b, ds);
    duty_q = {duty_q, ds};
    items_sent++;
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [37:0] make_emitter(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                               logic [11:0] cal, bit white, bit present);
    return {present, white, cal, b, g, r};
  endfunction

  always @(posedge clk) begin
    duty_set_t exp_d;
    if (rst_n && out_valid) begin
      results_seen++;
      if (duty_q.size() == 0) begin
        $display("%0t: unexpected result duties %h %h %h %h %h", $time,
                 out_duty_0, out_duty_1, out_duty_2, out_duty_3, out_duty_4);
        errors++;
      end else begin
        exp_d = duty_q.pop_front();
        if (exp_d.d0 !== out_duty_0) begin
          $display("%0t: duty_0 expected %0d actual %0d", $time, exp_d.d0, out_duty_0);
          errors++;
        end
        if (exp_d.d1 !== out_duty_1) begin
          $display("%0t: duty_1 expected %0d actual %0d", $time, exp_d.d1, out_duty_1);
          errors++;
        end
        if (exp_d.d2 !== out_duty_2) begin
          $display("%0t: duty_2 expected %0d actual %0d", $time, exp_d.d2, out_duty_2);
          errors++;
        end
        if (exp_d.d3 !== out_duty_3) begin
          $display("%0t: duty_3 expected %0d actual %0d", $time, exp_d.d3, out_duty_3);
          errors++;
        end
        if (exp_d.d4 !== out_duty_4) begin
          $display("%0t: duty_4 expected %0d actual %0d", $time, exp_d.d4, out_duty_4);
          errors++;
        end
      end
    end
  end

  task automatic test_lamp_off();
    send_color(8'hFF, 8'hFF, 8'hFF);
    send_color(8'h00, 8'h80, 8'h01);
  endtask

  task automatic test_basic_setup();
    write_reg(REG_EMIT0 + 3'd0, make_emitter(8'd255, 8'd200, 8'd120, 12'hFFF, 1, 1));
    write_reg(REG_EMIT0 + 3'd1, make_emitter(8'd120, 8'd200, 8'd255, 12'd3000, 1, 1));
    write_reg(REG_EMIT0 + 3'd2, make_emitter(8'd255, 8'd0, 8'd0, 12'hFFF, 0, 1));
    write_reg(REG_EMIT0 + 3'd3, make_emitter(8'd0, 8'd255, 8'd0, 12'd2048, 0, 1));
    write_reg(REG_EMIT0 + 3'd4, make_emitter(8'd0, 8'd0, 8'd255, 12'd1, 0, 1));
    write_reg(REG_LAMP, 38'd1);
    write_reg(REG_BAD, '1);
  endtask

  task automatic test_directed();
    send_color(8'd0, 8'd0, 8'd0);
    send_color(8'd255, 8'd255, 8'd255);
    send_color(8'd255, 8'd0, 8'd255);
    send_color(8'd1, 8'd1, 8'd1);
    send_color(8'd255, 8'd200, 8'd120);
    send_color(8'd120, 8'd200, 8'd255);
    send_color(8'd200, 8'd100, 8'd200);
    send_color(8'd255, 8'd10, 8'd1);
    send_color(8'd1, 8'd10, 8'd255);
    send_color(8'hAA, 8'h55, 8'hAA);
    send_color(8'h55, 8'hAA, 8'h55);
    // dark white, matching twins, zero calibration
    write_reg(REG_EMIT0 + 3'd2, make_emitter(8'd0, 8'd99, 8'd0, 12'd500, 1, 1));
    write_reg(REG_EMIT0 + 3'd3, make_emitter(8'd255, 8'd200, 8'd120, 12'd0, 1, 1));
    send_color(8'd255, 8'd200, 8'd120);
    send_color(8'd100, 8'd100, 8'd100);
    write_reg(REG_LEVEL, 38'd0);
    send_color(8'd255, 8'd255, 8'd255);
    write_reg(REG_LEVEL, 38'd1);
    send_color(8'd255, 8'd255, 8'd255);
    send_color(8'd128, 8'd1, 8'd128);
    write_reg(REG_LEVEL, 38'd255);
  endtask

  task automatic random_emitters();
    for (int i = 0; i < SLOTS; i++)
      write_reg(REG_EMIT0 + 3'(i),
                make_emitter(8'($urandom), ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
                             8'($urandom), 12'($urandom), $urandom_range(0, 1),
                             $urandom_range(0, 4) != 0));
    write_reg(REG_LEVEL, ($urandom_range(0, 3) == 0) ? 38'd255 : 38'($urandom_range(0, 255)));
    write_reg(REG_LAMP, ($urandom_range(0, 7) == 0) ? 38'd0 : 38'd1);
  endtask

  task automatic test_random();
    int burst;
    logic [7:0] r, g, b;
    for (int phase = 0; phase < 10; phase++) begin
      random_emitters();
      for (int k = 0; k < 38; k++) begin
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        if ($urandom_range(0, 9) == 0) g = 8'd0;
        if ($urandom_range(0, 9) == 0) r = 8'hFF;
        send_color(r, g, b);
        burst = $urandom_range(0, 3);
        if (burst == 0) idle_gap($urandom_range(1, 40));
        if (k == 20) wait_drained();
      end
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_want_red = '0;
    in_want_green = '0;
    in_want_blue = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < SLOTS; i++) emit_m[i] = '0;
    level_m = 8'd255;
    lamp_m = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_lamp_off();
    test_basic_setup();
    test_directed();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d colors over random emitter sets, levels and lamp states;", items_sent);
    $display("checked %0d duty results.", results_seen);
    if (errors == 0 && duty_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
